// ----- design/tert_pkg.sv -----
// Shared constants, opcodes and controller/datapath types of the timed edge reservation table.
`default_nettype none

package tert_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int NODE_BITS   = 16;
   localparam int TIME_BITS   = 32;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int WORD_BITS   = 2 * NODE_BITS + TIME_BITS;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_REMOVE = 3'd1,
      OP_HAS    = 3'd2,
      OP_BLOCKS = 3'd3,
      OP_CLEAR  = 3'd4,
      OP_EXPIRE = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

// ----- design/timed_edge_reservation_table.sv -----
// Top level of the timed edge reservation table: controller, datapath and checks.
//
//   Channel   Direction  Handshake             Beat contents
//   req_      in         req_valid/req_stall   opcode, from_node, to_node, expiry, now
//   rsp_      out        rsp_valid/rsp_stall   found, changed, status
//
// Every request reads all TABLE_DEPTH entries through the single read port of the
// entry RAM, one per cycle, then drains the last compare in ST_DRAIN and commits in
// ST_COMMIT; a new request is accepted only once the last one has committed. A
// response waiting under rsp_stall does not block the next request; only its commit
// waits for the response register. Reset empties the table at once through its
// valid bits.
`default_nettype none

module timed_edge_reservation_table (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [2:0]                     req_opcode,
   input  wire logic [tert_pkg::NODE_BITS-1:0] req_from_node,
   input  wire logic [tert_pkg::NODE_BITS-1:0] req_to_node,
   input  wire logic [tert_pkg::TIME_BITS-1:0] req_expiry,
   input  wire logic [tert_pkg::TIME_BITS-1:0] req_now,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_found,
   output logic                                rsp_changed,
   output logic                                rsp_status
);

   import tert_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   tert_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .cmd      (cmd),
      .stat     (stat)
   );

   tert_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_opcode   (req_opcode),
      .req_from_node(req_from_node),
      .req_to_node  (req_to_node),
      .req_expiry   (req_expiry),
      .req_now      (req_now),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_found    (rsp_found),
      .rsp_changed  (rsp_changed),
      .rsp_status   (rsp_status)
   );

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones({rsp_found, rsp_changed, rsp_status}) <= 1))
      else $error("More than one response flag set in one beat.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("Request side not stalled after accepting a beat.");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("Response appeared without a request in progress.");

endmodule

`default_nettype wire

// ----- design/tert_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tert_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- design/tert_ctrl.sv -----
// Controller state machine sequencing load, table scan and commit of one request.
`default_nettype none

module tert_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output tert_pkg::cmd_type       cmd,
   input  wire tert_pkg::stat_type stat
);

   import tert_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (stat.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- design/tert_dp.sv -----
// Datapath: request registers, entry RAM, valid bits, scan compare and response register.
`default_nettype none

module tert_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire tert_pkg::cmd_type              cmd,
   output tert_pkg::stat_type                  stat,
   input  wire logic [2:0]                     req_opcode,
   input  wire logic [tert_pkg::NODE_BITS-1:0] req_from_node,
   input  wire logic [tert_pkg::NODE_BITS-1:0] req_to_node,
   input  wire logic [tert_pkg::TIME_BITS-1:0] req_expiry,
   input  wire logic [tert_pkg::TIME_BITS-1:0] req_now,
   input  wire logic                           rsp_stall,
   output logic                                rsp_valid,
   output logic                                rsp_found,
   output logic                                rsp_changed,
   output logic                                rsp_status
);

   import tert_pkg::*;

   op_type                 op_ff,  op_in;
   logic [NODE_BITS-1:0]   a_ff,   a_in;
   logic [NODE_BITS-1:0]   b_ff,   b_in;
   logic [TIME_BITS-1:0]   exp_ff, exp_in;
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [IDX_BITS-1:0]    idx_ff, idx_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [IDX_BITS-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                   mark_ff, mark_in;
   logic                   hit_ff, hit_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_BITS-1:0]    free_idx_ff, free_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   found_ff, found_in;
   logic                   changed_ff, changed_in;
   logic                   status_ff, status_in;

   logic                   ram_we;
   logic [WORD_BITS-1:0]   rd_word;
   logic [NODE_BITS-1:0]   ent_from;
   logic [NODE_BITS-1:0]   ent_to;
   logic [TIME_BITS-1:0]   ent_exp;
   logic                   ent_v;
   logic                   dir_hit;
   logic                   rev_hit;

   assign ram_we = cmd.commit && (op_ff == OP_ADD) && !hit_ff && free_found_ff;

   tert_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(TABLE_DEPTH)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(free_idx_ff),
      .wr_data({a_ff, b_ff, exp_ff}),
      .rd_en  (cmd.scan),
      .rd_addr(idx_ff),
      .rd_data(rd_word)
   );

   assign ent_from = rd_word[WORD_BITS-1 -: NODE_BITS];
   assign ent_to   = rd_word[TIME_BITS +: NODE_BITS];
   assign ent_exp  = rd_word[TIME_BITS-1:0];
   assign ent_v    = valid_ff[cmp_idx_ff];
   assign dir_hit  = cmp_vld_ff && ent_v && (ent_from == a_ff) && (ent_to == b_ff);
   assign rev_hit  = cmp_vld_ff && ent_v && (ent_from == b_ff) && (ent_to == a_ff);

   assign stat.scan_last = (idx_ff == IDX_BITS'(TABLE_DEPTH - 1));
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      exp_in        = exp_ff;
      now_in        = now_ff;
      idx_in        = idx_ff;
      cmp_vld_in    = cmd.scan;
      cmp_idx_in    = idx_ff;
      valid_in      = valid_ff;
      mark_in       = mark_ff;
      hit_in        = hit_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      found_in      = found_ff;
      changed_in    = changed_ff;
      status_in     = status_ff;

      if (cmd.load) begin
         op_in         = op_type'(req_opcode);
         a_in          = req_from_node;
         b_in          = req_to_node;
         exp_in        = req_expiry;
         now_in        = req_now;
         idx_in        = '0;
         hit_in        = 1'b0;
         free_found_in = 1'b0;
      end else if (cmd.scan) begin
         idx_in = idx_ff + 1'b1;
      end

      if (cmp_vld_ff) begin
         if (dir_hit || ((op_ff == OP_BLOCKS) && rev_hit)) begin
            hit_in = 1'b1;
         end
         if (!ent_v && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_idx_ff;
         end
         if (((op_ff == OP_REMOVE) && dir_hit) ||
             ((op_ff == OP_EXPIRE) && ent_v && (ent_exp < now_ff))) begin
            valid_in[cmp_idx_ff] = 1'b0;
            mark_in              = 1'b1;
         end
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         found_in     = ((op_ff == OP_HAS) || (op_ff == OP_BLOCKS)) && hit_ff;
         changed_in   = (op_ff == OP_EXPIRE) && mark_ff;
         status_in    = (op_ff == OP_ADD) && !hit_ff && !free_found_ff;
         case (op_ff)
            OP_ADD: begin
               if (!hit_ff && free_found_ff) begin
                  valid_in[free_idx_ff] = 1'b1;
                  mark_in               = 1'b1;
               end
            end
            OP_CLEAR: begin
               if (|valid_ff) begin
                  mark_in = 1'b1;
               end
               valid_in = '0;
            end
            OP_EXPIRE: begin
               mark_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         cmp_vld_ff    <= 1'b0;
         valid_ff      <= '0;
         mark_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         cmp_vld_ff    <= cmp_vld_in;
         valid_ff      <= valid_in;
         mark_ff       <= mark_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      exp_ff      <= exp_in;
      now_ff      <= now_in;
      cmp_idx_ff  <= cmp_idx_in;
      free_idx_ff <= free_idx_in;
      found_ff    <= found_in;
      changed_ff  <= changed_in;
      status_ff   <= status_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_found   = found_ff;
   assign rsp_changed = changed_ff;
   assign rsp_status  = status_ff;

endmodule

`default_nettype wire

// ----- test/edge_reservation_checker.sv -----
// Checker that predicts and compares every response beat of the timed edge reservation table.

module edge_reservation_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [2:0]                     req_opcode,
   input  logic [tert_pkg::NODE_BITS-1:0] req_from_node,
   input  logic [tert_pkg::NODE_BITS-1:0] req_to_node,
   input  logic [tert_pkg::TIME_BITS-1:0] req_expiry,
   input  logic [tert_pkg::TIME_BITS-1:0] req_now,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           rsp_found,
   input  logic                           rsp_changed,
   input  logic                           rsp_status,
   output int                             fail_count,
   output int                             outstanding
);

   import tert_pkg::*;

   typedef struct packed {
      logic found;
      logic changed;
      logic status;
   } reply_type;

   reply_type            awaited_replies[$];
   reply_type            expected_reply;
   reply_type            actual_reply;
   logic                 slot_used[TABLE_DEPTH];
   logic [NODE_BITS-1:0] slot_from[TABLE_DEPTH];
   logic [NODE_BITS-1:0] slot_to[TABLE_DEPTH];
   logic [TIME_BITS-1:0] slot_expiry[TABLE_DEPTH];
   logic                 touched_mark;
   int                   mismatch_count;

   function automatic int slot_of(input logic [NODE_BITS-1:0] a, input logic [NODE_BITS-1:0] b);
      int hit;
      hit = -1;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (slot_used[i] && slot_from[i] == a && slot_to[i] == b) begin
            hit = i;
         end
      end
      return hit;
   endfunction

   task automatic predict_reply(input logic [2:0] op, input logic [NODE_BITS-1:0] a,
                                input logic [NODE_BITS-1:0] b,
                                input logic [TIME_BITS-1:0] lapse,
                                input logic [TIME_BITS-1:0] now);
      reply_type reply;
      int        free_slot;
      reply = '0;
      case (op)
         OP_ADD: begin
            if (slot_of(a, b) < 0) begin
               free_slot = -1;
               for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
                  if (!slot_used[i]) begin
                     free_slot = i;
                  end
               end
               if (free_slot < 0) begin
                  reply.status = 1'b1;
               end else begin
                  slot_used[free_slot]   = 1'b1;
                  slot_from[free_slot]   = a;
                  slot_to[free_slot]     = b;
                  slot_expiry[free_slot] = lapse;
                  touched_mark           = 1'b1;
               end
            end
         end
         OP_REMOVE: begin
            free_slot = slot_of(a, b);
            if (free_slot >= 0) begin
               slot_used[free_slot] = 1'b0;
               touched_mark         = 1'b1;
            end
         end
         OP_HAS: begin
            reply.found = (slot_of(a, b) >= 0);
         end
         OP_BLOCKS: begin
            reply.found = (slot_of(a, b) >= 0) || (slot_of(b, a) >= 0);
         end
         OP_CLEAR: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_used[i]) begin
                  slot_used[i] = 1'b0;
                  touched_mark = 1'b1;
               end
            end
         end
         OP_EXPIRE: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_used[i] && slot_expiry[i] < now) begin
                  slot_used[i] = 1'b0;
                  touched_mark = 1'b1;
               end
            end
            reply.changed = touched_mark;
            touched_mark  = 1'b0;
         end
         default: begin
         end
      endcase
      awaited_replies.insert(awaited_replies.size(), reply);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            slot_used[i] = 1'b0;
         end
         touched_mark   = 1'b0;
         awaited_replies.delete();
         fail_count     = 0;
         mismatch_count = 0;
         outstanding    = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_reply(req_opcode, req_from_node, req_to_node, req_expiry, req_now);
         end
         if (rsp_valid && !rsp_stall) begin
            actual_reply = {rsp_found, rsp_changed, rsp_status};
            if (awaited_replies.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("checker: unexpected response beat found=%b changed=%b status=%b",
                           rsp_found, rsp_changed, rsp_status);
               end
               mismatch_count++;
               fail_count++;
            end else begin
               expected_reply = awaited_replies.pop_front();
               if (expected_reply !== actual_reply) begin
                  if (mismatch_count < 10) begin
                     $display({"checker: response mismatch, expected found=%b changed=%b ",
                               "status=%b, got found=%b changed=%b status=%b"},
                              expected_reply.found, expected_reply.changed,
                              expected_reply.status, actual_reply.found,
                              actual_reply.changed, actual_reply.status);
                  end
                  mismatch_count++;
                  fail_count++;
               end
            end
         end
         outstanding = awaited_replies.size();
      end
   end

endmodule

// ----- test/testbench.sv -----
// Top of the testbench: clock, reset, request stimulus, response stalls and the verdict.

module testbench;
   import tert_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int BEATS_PER_PHASE = 219;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [2:0]           req_opcode = '0;
   logic [NODE_BITS-1:0] req_from_node = '0;
   logic [NODE_BITS-1:0] req_to_node = '0;
   logic [TIME_BITS-1:0] req_expiry = '0;
   logic [TIME_BITS-1:0] req_now = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_found;
   logic                 rsp_changed;
   logic                 rsp_status;
   int                   fail_count;
   int                   outstanding;
   int                   cycle_count = 0;
   int                   idle_pct = 0;
   int                   stall_pct = 0;
   logic [NODE_BITS-1:0] node_pool[8];

   timed_edge_reservation_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_from_node(req_from_node), .req_to_node(req_to_node),
      .req_expiry(req_expiry), .req_now(req_now),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_found(rsp_found),
      .rsp_changed(rsp_changed), .rsp_status(rsp_status)
   );

   edge_reservation_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_from_node(req_from_node), .req_to_node(req_to_node),
      .req_expiry(req_expiry), .req_now(req_now),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_found(rsp_found),
      .rsp_changed(rsp_changed), .rsp_status(rsp_status),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99, 0) < stall_pct);
   end

   task automatic send_beat(input logic [2:0] op, input logic [NODE_BITS-1:0] a,
                            input logic [NODE_BITS-1:0] b,
                            input logic [TIME_BITS-1:0] lapse,
                            input logic [TIME_BITS-1:0] now);
      while ($urandom_range(99, 0) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_from_node <= a;
      req_to_node   <= b;
      req_expiry    <= lapse;
      req_now       <= now;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic [NODE_BITS-1:0] pick_node();
      if ($urandom_range(99, 0) < 85) begin
         return node_pool[$urandom_range(7, 0)];
      end
      return NODE_BITS'($urandom);
   endfunction

   initial begin
      int                   idle_by_phase[4];
      int                   stall_by_phase[4];
      int                   roll;
      logic [2:0]           op;
      logic [TIME_BITS-1:0] tick;
      logic [TIME_BITS-1:0] lapse;
      logic [TIME_BITS-1:0] now;
      idle_by_phase  = '{0, 64, 0, 26};
      stall_by_phase = '{0, 0, 64, 26};
      node_pool = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom)};
      tick = $urandom;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty table: expire and clear change nothing, and clear leaves the mark alone.
      send_beat(OP_EXPIRE, 16'h0000, 16'h0000, 32'h0, 32'h0);
      send_beat(OP_CLEAR,  16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_beat(OP_EXPIRE, 16'h0000, 16'h0000, 32'h0, 32'h0);
      // Extreme edges, a stale add and a duplicate add.
      send_beat(OP_ADD,    16'h0000, 16'h0000, 32'hFFFFFFFF, 32'h0);
      send_beat(OP_ADD,    16'hFFFF, 16'hFFFF, 32'h0, 32'hFFFFFFFF);
      send_beat(OP_ADD,    16'h0000, 16'h0000, 32'h5, 32'h0);
      send_beat(OP_HAS,    16'h0000, 16'h0000, 32'h0, 32'h0);
      send_beat(OP_HAS,    16'hFFFF, 16'h0000, 32'h0, 32'h0);
      // Direction matters for has but not for blocks.
      send_beat(OP_ADD,    16'h1234, 16'hABCD, 32'd100, 32'd50);
      send_beat(OP_BLOCKS, 16'hABCD, 16'h1234, 32'h0, 32'h0);
      send_beat(OP_HAS,    16'hABCD, 16'h1234, 32'h0, 32'h0);
      send_beat(OP_BLOCKS, 16'h1234, 16'hABCD, 32'h0, 32'h0);
      send_beat(OP_REMOVE, 16'hABCD, 16'h1234, 32'h0, 32'h0);
      // Expiry is strict: an entry lapsing exactly now survives.
      send_beat(OP_EXPIRE, 16'h0000, 16'h0000, 32'h0, 32'd100);
      send_beat(OP_EXPIRE, 16'h0000, 16'h0000, 32'h0, 32'd100);
      send_beat(OP_EXPIRE, 16'h0000, 16'h0000, 32'h0, 32'd101);
      send_beat(OP_HAS,    16'h1234, 16'hABCD, 32'h0, 32'h0);
      send_beat(OP_REMOVE, 16'h0000, 16'h0000, 32'h0, 32'h0);
      send_beat(3'd6,      16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_beat(3'd7,      16'h0000, 16'h0000, 32'h0, 32'h0);
      send_beat(OP_ADD,    16'h5555, 16'hAAAA, 32'hAAAAAAAA, 32'h55555555);
      send_beat(OP_CLEAR,  16'h0000, 16'h0000, 32'h0, 32'h0);
      send_beat(OP_EXPIRE, 16'h0000, 16'h0000, 32'h0, 32'hFFFFFFFF);
      send_beat(OP_BLOCKS, 16'hAAAA, 16'h5555, 32'h0, 32'h0);

      // A small node pool and long lifetimes keep the table filling up to full.
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = idle_by_phase[phase];
         stall_pct = stall_by_phase[phase];
         repeat (BEATS_PER_PHASE) begin
            roll = $urandom_range(99, 0);
            if (roll < 40) begin
               op = OP_ADD;
            end else if (roll < 52) begin
               op = OP_REMOVE;
            end else if (roll < 64) begin
               op = OP_HAS;
            end else if (roll < 76) begin
               op = OP_BLOCKS;
            end else if (roll < 78) begin
               op = OP_CLEAR;
            end else if (roll < 94) begin
               op = OP_EXPIRE;
            end else begin
               op = 3'($urandom_range(7, 6));
            end
            tick = tick + $urandom_range(20, 0);
            now  = ($urandom_range(99, 0) < 90) ? tick : $urandom;
            roll = $urandom_range(99, 0);
            if (roll < 70) begin
               lapse = tick + $urandom_range(2000, 0);
            end else if (roll < 85) begin
               lapse = tick - $urandom_range(50, 0);
            end else begin
               lapse = $urandom;
            end
            send_beat(op, pick_node(), pick_node(), lapse, now);
         end
      end
      req_valid <= 1'b0;
      idle_pct  = 0;
      stall_pct = 0;

      while (outstanding != 0) begin
         @(negedge clock);
      end
      repeat (2 * (TABLE_DEPTH + 3)) @(negedge clock);
      if (fail_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/tert_pkg.sv
design/tert_ram.sv
design/tert_ctrl.sv
design/tert_dp.sv
design/timed_edge_reservation_table.sv
test/edge_reservation_checker.sv
test/testbench.sv
